@@ rtl/tcw_pkg.sv @@
// Shared types, constants and command codes of the text console writer.
package tcw_pkg;

	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0d;
	localparam logic [7:0] CH_LF       = 8'h0a;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] RESET_COLOR = 8'h0f;
	localparam int         TAB_STOP    = 4;

	typedef enum logic [1:0] {
		OP_PRINT = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMD_PUT,
		CMD_TAB,
		CMD_NEWLINE,
		CMD_NOP,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} request_t;

	typedef struct packed {
		logic [6:0] cursor_column;
		logic [4:0] cursor_row;
		logic [7:0] cell_char;
		logic [7:0] cell_color;
	} result_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} cmd_t;

endpackage

@@ rtl/text_console_writer.sv @@
// Text console: a printable byte, newline or carriage return is queued, then run by the sequencer.
// A tab writes up to 3 extra spaces; a scroll blanks the COLUMNS cells of the bottom row.
// A clear rewrites all ROWS*COLUMNS cells; a read goes through ST_RD_ADDR and ST_RD_DATA.
// The back-stage sequencer runs one command at a time and waits in ST_DONE while the result queue is full.
// After reset a fill pass writes ROWS*COLUMNS cells with full held high; configuration writes
// are taken during it and the cursor starts at home.
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  tcw_pkg::request_t request,
	output logic              empty,
	input  logic              pop,
	output tcw_pkg::result_t  result,
	input  logic              config_valid,
	output logic              config_ready,
	input  logic [7:0]        config_data
);

	localparam int RES_W = $bits(tcw_pkg::result_t);

	logic             cmd_valid;
	tcw_pkg::cmd_t    cmd;
	logic             cmd_pop;
	logic             init_busy;
	logic             res_push;
	tcw_pkg::result_t res_data;
	logic             res_full;
	logic [RES_W-1:0] result_bits;

	assign config_ready = 1'b1;
	assign result       = tcw_pkg::result_t'(result_bits);

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.hold      (init_busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.config_valid (config_valid && config_ready),
		.config_data  (config_data),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.init_busy    (init_busy),
		.res_push     (res_push),
		.res_data     (res_data),
		.res_full     (res_full)
	);

	tcw_fifo #(
		.DATA_W(RES_W)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result_bits),
		.empty   (empty)
	);

endmodule

@@ rtl/tcw_fifo.sv @@
// Two-entry first-in first-out queue used for the console's command and result queues.
module tcw_fifo #(
	parameter int DATA_W = $bits(tcw_pkg::result_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              empty
);

	logic [DATA_W-1:0] slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/tcw_front.sv @@
// Front stage: accepts requests, classifies them into commands and queues them.
module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tcw_pkg::request_t  request,
	input  logic               hold,
	output logic               cmd_valid,
	output tcw_pkg::cmd_t      cmd,
	input  logic               cmd_pop
);

	localparam int CMD_W = $bits(tcw_pkg::cmd_t);

	tcw_pkg::cmd_t    cmd_in;
	logic [CMD_W-1:0] cmd_bits;
	logic             q_full;
	logic             q_empty;
	logic             accept;

	always_comb begin
		cmd_in.char_code   = request.char_code;
		cmd_in.read_row    = request.read_row;
		cmd_in.read_column = request.read_column;
		case (request.operation)
			tcw_pkg::OP_PRINT: begin
				case (request.char_code)
					tcw_pkg::CH_TAB: cmd_in.kind = tcw_pkg::CMD_TAB;
					tcw_pkg::CH_CR:  cmd_in.kind = tcw_pkg::CMD_NOP;
					tcw_pkg::CH_LF:  cmd_in.kind = tcw_pkg::CMD_NEWLINE;
					default:         cmd_in.kind = tcw_pkg::CMD_PUT;
				endcase
			end
			tcw_pkg::OP_CLEAR: cmd_in.kind = tcw_pkg::CMD_CLEAR;
			tcw_pkg::OP_READ: begin
				// A read outside the screen reports zero cell fields, like a no-op.
				if (32'(request.read_row) < ROWS && 32'(request.read_column) < COLUMNS) begin
					cmd_in.kind = tcw_pkg::CMD_READ;
				end else begin
					cmd_in.kind = tcw_pkg::CMD_NOP;
				end
			end
			default: cmd_in.kind = tcw_pkg::CMD_NOP;
		endcase
	end

	assign full      = q_full || hold;
	assign accept    = push && !full;
	assign cmd_valid = !q_empty;
	assign cmd       = tcw_pkg::cmd_t'(cmd_bits);

	tcw_fifo #(
		.DATA_W(CMD_W)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (cmd_in),
		.full    (q_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_bits),
		.empty   (q_empty)
	);

endmodule

@@ rtl/tcw_back.sv @@
// Back stage: cursor sequencer, scroll ring and the character cell memory.
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              config_valid,
	input  logic [7:0]        config_data,
	input  logic              cmd_valid,
	input  tcw_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	output logic              init_busy,
	output logic              res_push,
	output tcw_pkg::result_t  res_data,
	input  logic              res_full
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_TAB,
		ST_BLANK,
		ST_CLEAR,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cx_q;
	logic [RW-1:0]   cy_q;
	logic [RW-1:0]   base_q;
	logic [AW-1:0]   fill_q;
	logic [AW-1:0]   blank_addr_q;
	logic [CW-1:0]   blank_col_q;
	logic [AW-1:0]   rd_addr_q;
	logic [7:0]      text_color_q;
	logic [15:0]     cell_q;
	logic [15:0]     rdata_q;
	logic [15:0]     cells_mem [CELLS];

	logic            wrap;
	logic            last_row;
	logic            tab_more;
	logic [CW-1:0]   cx_inc;
	logic [RW-1:0]   base_inc;
	logic [RW-1:0]   lf_cy;
	logic [RW-1:0]   lf_base;
	logic [CW-1:0]   step_cx;
	logic [RW-1:0]   step_cy;
	logic [RW-1:0]   step_base;
	logic [AW-1:0]   cursor_addr;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [15:0]     mem_wdata;

	// Rows live in a ring: logical row r sits at physical row (base + r) mod ROWS.
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
			input logic [RW-1:0] row);
		logic [RW:0] sum;
		sum = {1'b0, base} + {1'b0, row};
		if (32'(sum) >= ROWS) begin
			sum = sum - (RW+1)'(ROWS);
		end
		return sum[RW-1:0];
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
			input logic [CW-1:0] col);
		return AW'(32'(prow) * COLUMNS + 32'(col));
	endfunction

	assign wrap        = (32'(cx_q) == COLUMNS - 1);
	assign last_row    = (32'(cy_q) == ROWS - 1);
	assign cx_inc      = cx_q + 1'b1;
	assign base_inc    = (32'(base_q) == ROWS - 1) ? '0 : base_q + 1'b1;
	assign lf_cy       = last_row ? cy_q : cy_q + 1'b1;
	assign lf_base     = last_row ? base_inc : base_q;
	assign step_cx     = wrap ? '0 : cx_inc;
	assign step_cy     = wrap ? lf_cy : cy_q;
	assign step_base   = wrap ? lf_base : base_q;
	assign tab_more    = !wrap && ((32'(cx_inc) % tcw_pkg::TAB_STOP) != 0);
	assign cursor_addr = cell_addr(phys_row(base_q, cy_q), cx_q);

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign init_busy = (state_q == ST_INIT);
	assign res_push  = (state_q == ST_DONE) && !res_full;

	assign res_data.cursor_column = 7'(cx_q);
	assign res_data.cursor_row    = 5'(cy_q);
	assign res_data.cell_char     = cell_q[7:0];
	assign res_data.cell_color    = cell_q[15:8];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cursor_addr;
		mem_wdata = {text_color_q, tcw_pkg::CH_SPACE};
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = fill_q;
				mem_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = fill_q;
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = blank_addr_q;
			end
			ST_TAB: mem_we = 1'b1;
			ST_IDLE: begin
				if (cmd_valid && cmd.kind == tcw_pkg::CMD_PUT) begin
					mem_we    = 1'b1;
					mem_wdata = {text_color_q, cmd.char_code};
				end else if (cmd_valid && cmd.kind == tcw_pkg::CMD_TAB) begin
					mem_we = 1'b1;
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cells_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= cells_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cx_q         <= '0;
			cy_q         <= '0;
			base_q       <= '0;
			fill_q       <= '0;
			blank_addr_q <= '0;
			blank_col_q  <= '0;
			rd_addr_q    <= '0;
			cell_q       <= '0;
			text_color_q <= tcw_pkg::RESET_COLOR;
		end else begin
			if (config_valid) begin
				text_color_q <= config_data;
			end
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (32'(fill_q) == CELLS - 1) begin
						fill_q  <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cell_q <= '0;
						case (cmd.kind)
							tcw_pkg::CMD_PUT, tcw_pkg::CMD_TAB: begin
								cx_q   <= step_cx;
								cy_q   <= step_cy;
								base_q <= step_base;
								if (wrap && last_row) begin
									// The physical row that drops off the top becomes the blank bottom.
									blank_addr_q <= cell_addr(base_q, '0);
									blank_col_q  <= '0;
									state_q      <= ST_BLANK;
								end else if (cmd.kind == tcw_pkg::CMD_TAB && tab_more) begin
									state_q <= ST_TAB;
								end else begin
									state_q <= ST_DONE;
								end
							end
							tcw_pkg::CMD_NEWLINE: begin
								cx_q   <= '0;
								cy_q   <= lf_cy;
								base_q <= lf_base;
								if (last_row) begin
									blank_addr_q <= cell_addr(base_q, '0);
									blank_col_q  <= '0;
									state_q      <= ST_BLANK;
								end else begin
									state_q <= ST_DONE;
								end
							end
							tcw_pkg::CMD_CLEAR: begin
								cx_q    <= '0;
								cy_q    <= '0;
								base_q  <= '0;
								fill_q  <= '0;
								state_q <= ST_CLEAR;
							end
							tcw_pkg::CMD_READ: begin
								rd_addr_q <= cell_addr(phys_row(base_q, RW'(cmd.read_row)),
									CW'(cmd.read_column));
								state_q   <= ST_RD_ADDR;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_TAB: begin
					cx_q   <= step_cx;
					cy_q   <= step_cy;
					base_q <= step_base;
					if (wrap && last_row) begin
						blank_addr_q <= cell_addr(base_q, '0);
						blank_col_q  <= '0;
						state_q      <= ST_BLANK;
					end else if (!tab_more) begin
						state_q <= ST_DONE;
					end
				end
				ST_BLANK: begin
					blank_addr_q <= blank_addr_q + 1'b1;
					blank_col_q  <= blank_col_q + 1'b1;
					if (32'(blank_col_q) == COLUMNS - 1) begin
						state_q <= ST_DONE;
					end
				end
				ST_RD_ADDR: state_q <= ST_RD_DATA;
				ST_RD_DATA: begin
					cell_q  <= rdata_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cx_q) < COLUMNS)
		else $error("cursor column left the screen");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cy_q) < ROWS && 32'(base_q) < ROWS)
		else $error("cursor row or ring base out of range");

	a_blank_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLANK) |-> (cx_q == '0 && 32'(cy_q) == ROWS - 1))
		else $error("scroll blanking with cursor off the bottom line start");

	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (cx_q == '0 && cy_q == '0 && base_q == '0))
		else $error("clear pass running with cursor not at home");

	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q != ST_IDLE))
		else $error("command taken without being carried out");

endmodule
